// File: design/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

`endif

// File: design/cwd_pkg.sv
// Shared types, constants and the CRC-8 function of the word deframer.
// No dependencies.
`timescale 1ns / 1ps

package cwd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [4:0] WPR_RESET = 5'd2;

  typedef struct packed {
    logic [15:0] word_value;
    logic        crc_ok;
    logic [3:0]  word_index;
    logic        last_word;
  } cwd_result_t;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: design/cwd_out_buf.sv
// Two-entry result buffer between the framing logic and the output channel.
// Depends on cwd_pkg (result struct) and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cwd_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cwd_pkg::cwd_result_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_ready,
  output cwd_pkg::cwd_result_t out_data
);

  logic                 head_vld_r, head_vld_nxt;
  logic                 tail_vld_r, tail_vld_nxt;
  cwd_pkg::cwd_result_t head_r, head_nxt;
  cwd_pkg::cwd_result_t tail_r, tail_nxt;
  logic                 pop;

  assign pop       = head_vld_r && out_ready;
  assign full      = tail_vld_r;
  assign out_valid = head_vld_r;
  assign out_data  = head_r;

  always_comb begin
    head_vld_nxt = head_vld_r;
    tail_vld_nxt = tail_vld_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    if (pop) begin
      if (tail_vld_r) begin
        head_nxt     = tail_r;
        tail_vld_nxt = push;
        tail_nxt     = push_data;
      end else begin
        head_vld_nxt = push;
        head_nxt     = push_data;
      end
    end else if (push) begin
      if (head_vld_r) begin
        tail_vld_nxt = 1'b1;
        tail_nxt     = push_data;
      end else begin
        head_vld_nxt = 1'b1;
        head_nxt     = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      tail_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      tail_vld_r <= tail_vld_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  // tail entry never holds data without a head entry
  `ASSERT_SAME(a_tail_needs_head, tail_vld_r, head_vld_r)
  // push is never offered into a full buffer
  `ASSERT_SAME(a_no_push_full, push, !tail_vld_r)
  // a waiting head that is not taken stays in place
  `ASSERT_NEXT(a_head_holds, head_vld_r && !out_ready, head_vld_r && $stable(head_r))

endmodule

// File: design/crc_checked_word_deframer.sv
// CRC-8 (0x31, init 0xFF) checked word deframer: 3 bytes in, one word result out.
// Throughput: one byte per cycle; in_ready drops only when both result entries wait.
// A result enters the result buffer when its CRC byte is accepted; out_* show its head entry.
// Rate is set by the two-entry result buffer; framing state is registered per accepted byte.
// rst_n (synchronous, active low) resets phase, counter, CRC (to 0xFF), buffer; words_per_read = 2.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crc_checked_word_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // input channel: one reply byte per beat
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_read,
  // result channel: one beat per completed word
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_word_value,
  output logic        out_crc_ok,
  output logic [3:0]  out_word_index,
  output logic        out_last_word,
  // configuration: words_per_read
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  // Position within the three-byte group.
  typedef enum logic [1:0] {
    PH_HIGH,
    PH_LOW,
    PH_CRC
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_eff;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  high_r, high_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [3:0]  cnt_r, cnt_nxt, cnt_eff;
  logic [4:0]  wpr_r;
  logic        accept;
  logic        push;
  logic        buf_full;
  logic        is_last;
  cwd_pkg::cwd_result_t res, out_res;

  assign in_ready = !buf_full;
  assign accept   = in_valid && in_ready;

  // start_of_read restarts framing before this beat is used
  assign phase_eff = in_start_of_read ? PH_HIGH : phase_r;
  assign cnt_eff   = in_start_of_read ? 4'd0 : cnt_r;

  // last-word compare done at 5 bits, so 0 or >16 never matches
  assign is_last = ({1'b0, cnt_eff} == (wpr_r - 5'd1));

  always_comb begin
    res.word_value = {high_r, low_r};
    res.crc_ok     = (in_data_byte == crc_r);
    res.word_index = cnt_eff;
    res.last_word  = is_last;
  end

  always_comb begin
    phase_nxt = phase_r;
    crc_nxt   = crc_r;
    high_nxt  = high_r;
    low_nxt   = low_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    if (accept) begin
      cnt_nxt = cnt_eff;
      case (phase_eff)
        PH_LOW: begin
          low_nxt   = in_data_byte;
          crc_nxt   = cwd_pkg::crc8_byte(crc_r, in_data_byte);
          phase_nxt = PH_CRC;
        end
        PH_CRC: begin
          push      = 1'b1;
          crc_nxt   = cwd_pkg::CRC_INIT;
          phase_nxt = PH_HIGH;
          cnt_nxt   = is_last ? 4'd0 : cnt_eff + 4'd1;
        end
        default: begin
          // first byte of a word; stray phase code behaves the same
          high_nxt  = in_data_byte;
          crc_nxt   = cwd_pkg::crc8_byte(cwd_pkg::CRC_INIT, in_data_byte);
          phase_nxt = PH_LOW;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HIGH;
      crc_r   <= cwd_pkg::CRC_INIT;
      cnt_r   <= 4'd0;
      wpr_r   <= cwd_pkg::WPR_RESET;
    end else begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr_en) begin
        wpr_r <= cfg_wr_data;
      end
    end
    high_r <= high_nxt;
    low_r  <= low_nxt;
  end

  cwd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_word_value = out_res.word_value;
  assign out_crc_ok     = out_res.crc_ok;
  assign out_word_index = out_res.word_index;
  assign out_last_word  = out_res.last_word;

  // a result only comes from a CRC beat with no restart
  `ASSERT_SAME(a_push_on_crc, push, phase_r == PH_CRC && !in_start_of_read)
  // after a word completes, framing is back at the first byte with a fresh CRC
  `ASSERT_NEXT(a_word_done, push, phase_r == PH_HIGH && crc_r == cwd_pkg::CRC_INIT)
  // a restart beat always becomes the high byte of word zero
  `ASSERT_NEXT(a_restart, accept && in_start_of_read, phase_r == PH_LOW && cnt_r == 4'd0)

endmodule

// File: bench/tb.sv
// Self-checking bench for crc_checked_word_deframer: random bursty byte beats in,
// stalled result beats out, every word checked against an in-bench CRC-8 predictor.
// Depends on cwd_pkg (result type, CRC constants, reset value of words_per_read).
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT = 4000;  // cycles without any beat before giving up
  localparam int PHASE_BYTES = 85;

  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_LOW  = 2'd1,
    PH_CRC  = 2'd2
  } byte_slot_t;

  typedef struct packed {
    logic [7:0] data;
    logic       sor;
    logic       drain;  // hold this beat until every word in flight has come out
  } reply_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_start_of_read = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_word_value;
  logic        out_crc_ok;
  logic [3:0]  out_word_index;
  logic        out_last_word;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = 5'd0;

  crc_checked_word_deframer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_start_of_read (in_start_of_read),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_word_value   (out_word_value),
    .out_crc_ok       (out_crc_ok),
    .out_word_index   (out_word_index),
    .out_last_word    (out_last_word),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  reply_byte_t          reply_bytes[$];     // beats waiting for the driver
  cwd_pkg::cwd_result_t pending_words[$];   // words predicted but not yet seen on out_*
  int                   bytes_built = 0;
  int                   fail_count = 0;

  // Deframer shadow state
  byte_slot_t  slot;
  logic [7:0]  crc_acc;
  logic [7:0]  msb_byte;
  logic [7:0]  lsb_byte;
  logic [3:0]  word_cnt;
  logic [4:0]  words_cfg;

  // CRC-8, poly 0x31, bit-serial form, MSB first
  function automatic logic [7:0] crc_update(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r = {r[6:0], 1'b0} ^ (fb ? cwd_pkg::CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // Advance the shadow deframer by one accepted byte; a CRC byte yields a word.
  task automatic deframe_byte(input logic [7:0] b, input logic sor);
    cwd_pkg::cwd_result_t w;
    logic [4:0]  last_idx;
    if (sor) begin
      slot = PH_HIGH;
      word_cnt = 4'd0;
      crc_acc = cwd_pkg::CRC_INIT;
    end
    case (slot)
      PH_LOW: begin
        lsb_byte = b;
        crc_acc = crc_update(crc_acc, b);
        slot = PH_CRC;
      end
      PH_CRC: begin
        last_idx = words_cfg - 5'd1;  // wraps at 5 bits: zero config never marks last
        w.word_value = {msb_byte, lsb_byte};
        w.crc_ok = (b == crc_acc);
        w.word_index = word_cnt;
        w.last_word = ({1'b0, word_cnt} == last_idx);
        pending_words = {pending_words, w};
        word_cnt = w.last_word ? 4'd0 : word_cnt + 4'd1;
        slot = PH_HIGH;
        crc_acc = cwd_pkg::CRC_INIT;
      end
      default: begin
        msb_byte = b;
        crc_acc = crc_update(cwd_pkg::CRC_INIT, b);
        slot = PH_LOW;
      end
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus build

  task automatic add_byte(input logic [7:0] d, input logic sor, input logic drain = 1'b0);
    reply_byte_t rb;
    rb.data = d;
    rb.sor = sor;
    rb.drain = drain;
    reply_bytes = {reply_bytes, rb};
    bytes_built++;
  endtask

  // One framed word; a bad one gets its CRC byte flipped by a nonzero mask.
  task automatic add_word(input logic [7:0] hi, input logic [7:0] lo, input logic sor,
                          input logic bad, input logic drain = 1'b0);
    logic [7:0] crc;
    crc = crc_update(crc_update(cwd_pkg::CRC_INIT, hi), lo);
    if (bad) begin
      crc ^= 8'($urandom_range(1, 255));
    end
    add_byte(hi, sor, drain);
    add_byte(lo, 1'b0);
    add_byte(crc, 1'b0);
  endtask

  task automatic add_read(input int nw, input logic with_start, input logic drain);
    for (int i = 0; i < nw; i++) begin
      add_word(8'($urandom), 8'($urandom), with_start && (i == 0),
               $urandom_range(0, 7) == 0, drain && (i == 0));
    end
  endtask

  // Mostly well-formed reads, some overlong, headless or cut short, some noise.
  task automatic build_phase(input logic [4:0] wpr);
    int target;
    int kind;
    int nw;
    target = bytes_built + PHASE_BYTES;
    while (bytes_built < target) begin
      kind = $urandom_range(0, 9);
      nw = (wpr >= 5'd1 && wpr <= 5'd16) ? int'(wpr) : $urandom_range(1, 20);
      case (kind)
        0, 1, 2, 3, 4, 5: add_read(nw, 1'b1, $urandom_range(0, 29) == 0);
        6: add_read($urandom_range(1, 20), 1'b1, 1'b0);
        7: add_read(nw, 1'b0, 1'b0);
        8: begin
          // read abandoned mid-word, next read's start discards it
          add_read($urandom_range(0, 2), 1'b1, 1'b0);
          repeat ($urandom_range(1, 2)) add_byte(8'($urandom), 1'b0);
        end
        default: begin
          repeat ($urandom_range(1, 6)) add_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
      endcase
    end
  endtask

  // Idle means: nothing queued, nothing offered, no word outstanding.
  // Checked on the falling edge so all beat updates have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (reply_bytes.size() != 0 || in_valid || pending_words.size() != 0);
    repeat (3) @(posedge clk);  // result lags its CRC byte through the output buffer
  endtask

  task automatic write_words_cfg(input logic [4:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    words_cfg = v;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    logic [4:0] wpr_list[$];
    slot = PH_HIGH;
    crc_acc = cwd_pkg::CRC_INIT;
    msb_byte = 8'h00;
    lsb_byte = 8'h00;
    word_cnt = 4'd0;
    words_cfg = cwd_pkg::WPR_RESET;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, on the reset value of words_per_read (2).
    add_word(8'hFF, 8'hFF, 1'b1, 1'b0);          // extremes, good CRC
    add_word(8'h00, 8'h00, 1'b0, 1'b0);          // last word of the read
    add_word(8'h80, 8'h01, 1'b0, 1'b1);          // after the last word: fresh read, bad CRC
    add_byte(8'h12, 1'b1);                       // partial word...
    add_byte(8'h34, 1'b0);
    add_word(8'hA5, 8'h5A, 1'b1, 1'b0, 1'b1);    // ...dropped by start on the CRC slot
    add_byte(8'h77, 1'b0);
    add_word(8'h01, 8'hFE, 1'b1, 1'b0);          // start on the low-byte slot
    add_byte(8'hFF, 1'b0);                       // word whose CRC byte is all ones
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);                       // word whose CRC byte is all zeros
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    wait_idle();

    // Extremes first (zero and above sixteen never mark last), then random sizes.
    wpr_list = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17};
    repeat (9) wpr_list = {wpr_list, 5'($urandom_range(1, 16))};
    foreach (wpr_list[i]) begin
      write_words_cfg(wpr_list[i]);
      build_phase(wpr_list[i]);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    reply_byte_t rb;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_byte(in_data_byte, in_start_of_read);
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (reply_bytes.size() == 0 ||
                     (reply_bytes[0].drain && pending_words.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          rb = reply_bytes.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= rb.data;
          in_start_of_read <= rb.sor;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            // new burst; some long and gapless
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  int stall_mode = 0;
  int mode_left = 0;
  int stall_tick = 0;

  always @(posedge clk) begin
    cwd_pkg::cwd_result_t w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          note_failure($sformatf("unexpected word: value=%h ok=%b idx=%0d last=%b",
                                 out_word_value, out_crc_ok, out_word_index, out_last_word));
        end else begin
          w = pending_words.pop_front();
          if (out_word_value !== w.word_value || out_crc_ok !== w.crc_ok ||
              out_word_index !== w.word_index || out_last_word !== w.last_word) begin
            note_failure($sformatf({"word mismatch: exp value=%h ok=%b idx=%0d last=%b, ",
                                    "got value=%h ok=%b idx=%0d last=%b"},
                                   w.word_value, w.crc_ok, w.word_index, w.last_word,
                                   out_word_value, out_crc_ok, out_word_index,
                                   out_last_word));
          end
        end
      end
      // stall pattern: always ready, coin flip, periodic ready pulses, or alternating ready/stalled runs
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      stall_tick++;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom);
        2: out_ready <= (stall_tick % 4) == 0;
        default: out_ready <= ((stall_tick / 8) % 2) == 0;
      endcase
    end
  end

  // ---------------------------------------------------------------- watchdog

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
